// ===== hw/rtl/hdm_pkg.sv =====
// ----------------------------------------------------------------------------
// hdm_pkg: shared types and constants for the Hamming descriptor matcher
// Request and match payloads, command codes, config register indexes and
// the controller to datapath command and status groups.
// ----------------------------------------------------------------------------
package hdm_pkg;

  localparam int MAX_REFS_DEFAULT = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIST_W     = 13;
  localparam int REF_OUT_W  = 10;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_RATIO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_PENALTY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_PEN    = 3'd4;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_EMPTY    = 2'd2
  } match_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] desc_word0;
    logic [63:0] desc_word1;
    logic [63:0] desc_word2;
    logic [63:0] desc_word3;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] query_id;
  } req_item_t;

  typedef struct packed {
    logic [15:0]          match_query;
    logic [REF_OUT_W-1:0] match_ref;
    logic [DIST_W-1:0]    match_distance;
    logic [1:0]           status;
  } match_item_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic issue;
    logic finish;
  } hdm_cmd_t;

  typedef struct packed {
    logic set_empty;
    logic scan_last;
    logic pipe_busy;
    logic out_full;
  } hdm_stat_t;

endpackage

// ===== hw/rtl/hamming_descriptor_matcher.sv =====
// ----------------------------------------------------------------------------
// hamming_descriptor_matcher: brute-force binary descriptor matcher
// Request channel (req_valid/req_stall/req_data) carries clear, load and
// query requests; the match channel returns one result per query.
//
// A clear or load request is taken without a stall. A load into a full set
// is dropped. A query reads the reference memory once per cycle, one
// stored entry at a time, through the single memory read port; each
// distance passes the four-stage distance pipeline into the best-match
// tracking, and the result enters the output register once the scan is
// done and the pipeline has drained (an empty set skips the scan).
// req_stall is high from a query's acceptance until its result
// has entered the output register. A stalled result holds, and a
// finished query waits for the output register before the block takes
// the next request. Config writes are taken whenever no request is open.
// Reset empties the reference set, drops any pending result and loads
// the config registers with their defaults; no memory clearing is done.
// ----------------------------------------------------------------------------
module hamming_descriptor_matcher
  import hdm_pkg::*;
#(
  parameter int MAX_REFS = MAX_REFS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_item_t             req_data,
  output logic                  match_valid,
  input  logic                  match_stall,
  output match_item_t           match_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  hdm_cmd_t  cmd;
  hdm_stat_t stat;

  hdm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req_data.command),
    .req_stall   (req_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  hdm_datapath #(
    .MAX_REFS (MAX_REFS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req_data    (req_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .match_valid (match_valid),
    .match_stall (match_stall),
    .match_data  (match_data)
  );

endmodule

// ===== hw/rtl/hdm_ctrl.sv =====
// ----------------------------------------------------------------------------
// hdm_ctrl: sequencing state machine of the descriptor matcher
// Takes requests while idle, steps the reference scan, waits for the
// datapath pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module hdm_ctrl
  import hdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_command,
  output logic       req_stall,
  input  hdm_stat_t  stat,
  output hdm_cmd_t   cmd
);

  ctrl_state_t state, state_next;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        accept    = req_valid;
        cmd.clear = accept && (req_command == CMD_CLEAR);
        cmd.load  = accept && (req_command == CMD_LOAD);
        cmd.start = accept && (req_command == CMD_QUERY);
        if (cmd.start) begin
          state_next = stat.set_empty ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_full) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/hdm_datapath.sv =====
// ----------------------------------------------------------------------------
// hdm_datapath: reference store, distance pipeline and best-match tracking
// Holds the config registers and the reference memory, computes one
// penalized Hamming distance per cycle and builds the match result.
// ----------------------------------------------------------------------------
module hdm_datapath
  import hdm_pkg::*;
#(
  parameter int MAX_REFS = MAX_REFS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  req_item_t             req_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  hdm_cmd_t              cmd,
  output hdm_stat_t             stat,
  output logic                  match_valid,
  input  logic                  match_stall,
  output match_item_t           match_data
);

  localparam int IW      = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int CW      = $clog2(MAX_REFS + 1);
  localparam int ENTRY_W = 256 + 32;

  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [6:0]  s;
    a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(c[8*i +: 8]);
    end
    return s;
  endfunction

  // config registers
  logic        use_ratio_test;
  logic [8:0]  ratio_threshold;
  logic        use_spatial_penalty;
  logic [15:0] jump_radius;
  logic [4:0]  pen_gain;
  logic [31:0] r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_ratio_test      <= 1'b1;
      ratio_threshold     <= 9'd205;
      use_spatial_penalty <= 1'b0;
      jump_radius         <= 16'd1600;
      pen_gain            <= 5'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_USE_RATIO:   use_ratio_test      <= cfg_data[0];
        CFG_RATIO_THR:   ratio_threshold     <= cfg_data[8:0];
        CFG_USE_PENALTY: use_spatial_penalty <= cfg_data[0];
        CFG_JUMP_RADIUS: jump_radius         <= cfg_data;
        CFG_JUMP_PEN:    pen_gain            <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= jump_radius * jump_radius;
  end

  // reference store
  logic [ENTRY_W-1:0] ref_mem [MAX_REFS];
  logic [CW-1:0]      ref_count;
  logic               set_full;
  logic               wr_en;
  logic [IW-1:0]      scan_idx;
  logic [ENTRY_W-1:0] rd_entry;

  assign set_full = (ref_count == CW'(MAX_REFS));
  assign wr_en    = cmd.load && !set_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
    end else if (cmd.clear) begin
      ref_count <= '0;
    end else if (wr_en) begin
      ref_count <= ref_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_mem[IW'(ref_count)] <= {req_data.pos_y, req_data.pos_x,
                                  req_data.desc_word3, req_data.desc_word2,
                                  req_data.desc_word1, req_data.desc_word0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_entry <= ref_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      scan_idx <= '0;
    end else if (cmd.issue) begin
      scan_idx <= scan_idx + IW'(1);
    end
  end

  // query latch
  logic [255:0] q_desc;
  logic [15:0]  q_x, q_y, q_id;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_desc <= {req_data.desc_word3, req_data.desc_word2,
                 req_data.desc_word1, req_data.desc_word0};
      q_x    <= req_data.pos_x;
      q_y    <= req_data.pos_y;
      q_id   <= req_data.query_id;
    end
  end

  // distance pipeline
  logic          va, vb, vc, vd;
  logic [IW-1:0] ia, ib, ic, id;
  logic [6:0]    pc [4];
  logic [15:0]   dx, dy;
  logic [8:0]    ham_dist;
  logic [31:0]   dx2, dy2;
  logic [DIST_W-1:0] dist_pen;
  logic [15:0]   rx, ry;
  logic          far;
  logic [13:0]   dist_mul;

  assign rx = rd_entry[256 +: 16];
  assign ry = rd_entry[272 +: 16];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= cmd.issue;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    ia <= scan_idx;
    ib <= ia;
    ic <= ib;
    id <= ic;
    for (int k = 0; k < 4; k++) begin
      pc[k] <= popcount64(rd_entry[64*k +: 64] ^ q_desc[64*k +: 64]);
    end
    dx       <= (q_x >= rx) ? (q_x - rx) : (rx - q_x);
    dy       <= (q_y >= ry) ? (q_y - ry) : (ry - q_y);
    ham_dist <= 9'(pc[0]) + 9'(pc[1]) + 9'(pc[2]) + 9'(pc[3]);
    dx2      <= dx * dx;
    dy2      <= dy * dy;
    dist_pen <= far ? DIST_W'(dist_mul) : DIST_W'(ham_dist);
  end

  assign far      = use_spatial_penalty && ((33'(dx2) + 33'(dy2)) > 33'(r2));
  assign dist_mul = ham_dist * pen_gain;

  // best and second-best tracking
  logic [DIST_W-1:0] best, second;
  logic [IW-1:0]     best_idx;
  logic              have_best, have_second;

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      have_best   <= 1'b0;
      have_second <= 1'b0;
    end else if (vd) begin
      if (!have_best || dist_pen < best) begin
        have_best <= 1'b1;
        if (have_best) begin
          have_second <= 1'b1;
        end
      end else if (!have_second || dist_pen < second) begin
        have_second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vd) begin
      if (!have_best || dist_pen < best) begin
        second   <= best;
        best     <= dist_pen;
        best_idx <= id;
      end else if (!have_second || dist_pen < second) begin
        second <= dist_pen;
      end
    end
  end

  // result
  logic          reject;
  logic [21:0]   best_scaled, thr_scaled;
  match_status_t res_status;

  assign best_scaled = {1'b0, best, 8'd0};
  assign thr_scaled  = ratio_threshold * second;
  assign reject      = use_ratio_test &&
                       (have_second ? (best_scaled >= thr_scaled)
                                    : (ratio_threshold == 9'd0));
  assign res_status  = !have_best ? ST_EMPTY : (reject ? ST_REJECTED : ST_ACCEPTED);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (cmd.finish) begin
      match_valid <= 1'b1;
    end else if (!match_stall) begin
      match_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      match_data.match_query    <= q_id;
      match_data.match_ref      <= have_best ? REF_OUT_W'(best_idx) : '0;
      match_data.match_distance <= have_best ? best : '0;
      match_data.status         <= res_status;
    end
  end

  assign stat.set_empty = (ref_count == '0);
  assign stat.scan_last = (CW'(scan_idx) == (ref_count - CW'(1)));
  assign stat.pipe_busy = va | vb | vc | vd;
  assign stat.out_full  = match_valid && match_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ref_count <= CW'(MAX_REFS))
    else $error("reference count above capacity");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (CW'(scan_idx) < ref_count))
    else $error("scan reads beyond the stored set");

  a_second_needs_best: assert property (@(posedge clk) disable iff (rst)
    have_second |-> have_best)
    else $error("second best without best");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> match_valid)
    else $error("finished match not presented");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !stat.pipe_busy)
    else $error("result taken while distances in flight");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hamming_descriptor_matcher
// Drives clear, load and query requests, runs a prediction of
// best match, penalty and ratio test, and compares every match result in
// order. A directed table comes first, then a larger-set pass and randomized
// clear/load/query episodes under several register settings and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  import hdm_pkg::*;

  localparam int REF_CAPACITY = MAX_REFS_DEFAULT;
  localparam int BIG_SET      = 60;
  localparam int PHASE_ITEMS  = 52;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [255:0] ZEROS = '0;
  localparam logic [255:0] ONES  = {256{1'b1}};
  localparam logic [255:0] ALT   = {64{4'hA}};

  typedef struct packed {
    req_item_t   req;
    logic        typed;
    match_item_t result;
  } stim_row_t;

  typedef struct packed {
    logic        ratio_on;
    logic [8:0]  ratio_thr;
    logic        penalty_on;
    logic [15:0] radius;
    logic [4:0]  penalty;
  } match_cfg_t;

  localparam match_cfg_t CFG_DEFAULT = '{1'b1, 9'd205, 1'b0, 16'd1600, 5'd2};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_item_t             req_data = '0;
  logic                  match_valid;
  logic                  match_stall = 1'b0;
  match_item_t           match_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted block state
  match_cfg_t   cur_cfg = CFG_DEFAULT;
  logic [255:0] ref_desc [REF_CAPACITY];
  logic [15:0]  ref_x [REF_CAPACITY];
  logic [15:0]  ref_y [REF_CAPACITY];
  int unsigned  ref_total = 0;
  match_item_t  expected_matches [$];
  int           fail_count = 0;

  // stimulus side copy of the loaded entries
  logic [255:0] ep_desc [REF_CAPACITY];
  logic [15:0]  ep_x [REF_CAPACITY];
  logic [15:0]  ep_y [REF_CAPACITY];
  int unsigned  ep_count = 0;
  int           items_sent = 0;
  int           snd_pct = 0;
  int           rcv_pct = 0;
  bit           hold_pending = 1'b0;
  logic         row_typed = 1'b0;
  match_item_t  row_result = '0;

  hamming_descriptor_matcher u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .match_valid(match_valid),
    .match_stall(match_stall),
    .match_data(match_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic match_item_t predict_match(req_item_t q);
    logic [255:0]    qd;
    int unsigned     d, best, second, best_idx, j;
    bit              have_best, have_second;
    longint unsigned dx, dy, r2;
    match_item_t     m;
    qd = {q.desc_word3, q.desc_word2, q.desc_word1, q.desc_word0};
    r2 = 64'(cur_cfg.radius);
    r2 = r2 * r2;
    best = 0;
    second = 0;
    best_idx = 0;
    have_best = 1'b0;
    have_second = 1'b0;
    for (j = 0; j < ref_total; j++) begin
      d = $countones(qd ^ ref_desc[j]);
      if (cur_cfg.penalty_on) begin
        dx = (q.pos_x > ref_x[j]) ? 64'(q.pos_x - ref_x[j]) : 64'(ref_x[j] - q.pos_x);
        dy = (q.pos_y > ref_y[j]) ? 64'(q.pos_y - ref_y[j]) : 64'(ref_y[j] - q.pos_y);
        if (dx * dx + dy * dy > r2) d = d * cur_cfg.penalty;
      end
      if (!have_best || d < best) begin
        if (have_best) begin
          second = best;
          have_second = 1'b1;
        end
        best = d;
        best_idx = j;
        have_best = 1'b1;
      end else if (!have_second || d < second) begin
        second = d;
        have_second = 1'b1;
      end
    end
    m.match_query = q.query_id;
    m.match_ref = REF_OUT_W'(best_idx);
    m.match_distance = DIST_W'(best);
    m.status = ST_ACCEPTED;
    if (!have_best) begin
      m.status = ST_EMPTY;
    end else if (cur_cfg.ratio_on) begin
      if (have_second) begin
        if (64'(best) * 256 >= 64'(cur_cfg.ratio_thr) * second) m.status = ST_REJECTED;
      end else if (cur_cfg.ratio_thr == 0) begin
        m.status = ST_REJECTED;
      end
    end
    return m;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // track accepted requests and config writes, check every accepted match
  always @(posedge clk) begin : scoreboard
    match_item_t want;
    if (rst) begin
      cur_cfg = CFG_DEFAULT;
      ref_total = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_USE_RATIO:   cur_cfg.ratio_on = cfg_data[0];
          CFG_RATIO_THR:   cur_cfg.ratio_thr = cfg_data[8:0];
          CFG_USE_PENALTY: cur_cfg.penalty_on = cfg_data[0];
          CFG_JUMP_RADIUS: cur_cfg.radius = cfg_data;
          CFG_JUMP_PEN:    cur_cfg.penalty = cfg_data[4:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        case (req_data.command)
          CMD_CLEAR: ref_total = 0;
          CMD_LOAD: begin
            if (ref_total < REF_CAPACITY) begin
              ref_desc[ref_total] = {req_data.desc_word3, req_data.desc_word2,
                                     req_data.desc_word1, req_data.desc_word0};
              ref_x[ref_total] = req_data.pos_x;
              ref_y[ref_total] = req_data.pos_y;
              ref_total++;
            end
          end
          CMD_QUERY: expected_matches.push_back(row_typed ? row_result
                                                          : predict_match(req_data));
          default: ;
        endcase
      end
      if (match_valid && !match_stall) begin
        if (expected_matches.size() == 0) begin
          $error("unexpected match for query %0d", match_data.match_query);
          fail_count++;
        end else begin
          want = expected_matches.pop_front();
          check_field("match_query", want.match_query, match_data.match_query);
          check_field("match_ref", 16'(want.match_ref), 16'(match_data.match_ref));
          check_field("match_distance", 16'(want.match_distance),
                      16'(match_data.match_distance));
          check_field("status", 16'(want.status), 16'(match_data.status));
        end
      end
    end
  end

  // random result stall, with one long hold on request
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        match_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      match_stall <= (rcv_pct != 0) && ($urandom_range(99) < rcv_pct);
    end
  end

  function automatic req_item_t make_req(logic [1:0] cmd, logic [255:0] d,
                                         logic [15:0] x, logic [15:0] y, logic [15:0] qid);
    req_item_t r;
    r.command = cmd;
    r.desc_word0 = d[63:0];
    r.desc_word1 = d[127:64];
    r.desc_word2 = d[191:128];
    r.desc_word3 = d[255:192];
    r.pos_x = x;
    r.pos_y = y;
    r.query_id = qid;
    return r;
  endfunction

  function automatic match_item_t match_of(logic [15:0] qid, logic [9:0] idx,
                                           logic [12:0] dist_val, match_status_t st);
    match_item_t m;
    m.match_query = qid;
    m.match_ref = idx;
    m.match_distance = dist_val;
    m.status = st;
    return m;
  endfunction

  function automatic stim_row_t row(logic [1:0] cmd, logic [255:0] d, logic [15:0] x,
                                    logic [15:0] y, logic [15:0] qid, logic typed = 1'b0,
                                    match_item_t result = '0);
    stim_row_t r;
    r.req = make_req(cmd, d, x, y, qid);
    r.typed = typed;
    r.result = result;
    return r;
  endfunction

  function automatic logic [255:0] rand_desc();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [15:0] rand_pos();
    return ($urandom_range(99) < 70) ? 16'($urandom_range(4095)) : 16'($urandom);
  endfunction

  function automatic logic [15:0] near_pos(logic [15:0] base);
    int v;
    v = int'(base) + int'($urandom_range(3000)) - 1500;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [255:0] flip_bits(logic [255:0] d, int unsigned count);
    int unsigned b;
    repeat (count) begin
      b = $urandom_range(255);
      d[b] = ~d[b];
    end
    return d;
  endfunction

  task automatic send_request(req_item_t item, logic typed = 1'b0, match_item_t result = '0);
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= item;
    row_typed <= typed;
    row_result <= result;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    if (item.command != CMD_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_matches.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                           int width);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (CFG_DATA_W'($urandom) << width) | value;
    @(posedge clk);
  endtask

  task automatic apply_cfg(match_cfg_t c);
    write_reg(CFG_USE_RATIO, CFG_DATA_W'(c.ratio_on), 1);
    write_reg(CFG_RATIO_THR, CFG_DATA_W'(c.ratio_thr), 9);
    write_reg(CFG_USE_PENALTY, CFG_DATA_W'(c.penalty_on), 1);
    write_reg(CFG_JUMP_RADIUS, c.radius, 16);
    write_reg(CFG_JUMP_PEN, CFG_DATA_W'(c.penalty), 5);
    cfg_we <= 1'b0;
  endtask

  // append one entry, often a near copy of the previous one
  task automatic load_entry();
    logic [255:0] d;
    logic [15:0]  x, y;
    d = rand_desc();
    x = rand_pos();
    y = rand_pos();
    if (ep_count > 0 && $urandom_range(99) < 20) begin
      d = flip_bits(ep_desc[ep_count-1], $urandom_range(1, 40));
      x = near_pos(ep_x[ep_count-1]);
      y = near_pos(ep_y[ep_count-1]);
    end
    if (ep_count < REF_CAPACITY) begin
      ep_desc[ep_count] = d;
      ep_x[ep_count] = x;
      ep_y[ep_count] = y;
      ep_count++;
    end
    send_request(make_req(CMD_LOAD, d, x, y, 16'($urandom)));
  endtask

  task automatic run_episode(int min_queries);
    int           n, nq, pick, i;
    int unsigned  j;
    logic [255:0] qd;
    logic [15:0]  qx, qy;
    n = $urandom_range(99);
    n = (n < 8) ? 0 : (n < 18) ? 1 : (n < 26) ? 2 : $urandom_range(3, 40);
    send_request(make_req(CMD_CLEAR, rand_desc(), rand_pos(), rand_pos(), 16'($urandom)));
    ep_count = 0;
    repeat (n) load_entry();
    nq = $urandom_range(min_queries, 6);
    for (i = 0; i < nq; i++) begin
      pick = $urandom_range(99);
      if (pick < 5)
        send_request(make_req(CMD_UNUSED, rand_desc(), rand_pos(), rand_pos(),
                              16'($urandom)));
      else if (pick < 10)
        load_entry();
      qd = rand_desc();
      qx = rand_pos();
      qy = rand_pos();
      if (ep_count > 0 && pick < 80) begin
        j = $urandom_range(ep_count - 1);
        qd = flip_bits(ep_desc[j], $urandom_range(0, 24));
        if (pick < 65) begin
          qx = near_pos(ep_x[j]);
          qy = near_pos(ep_y[j]);
        end
      end
      send_request(make_req(CMD_QUERY, qd, qx, qy, 16'($urandom)));
    end
  endtask

  initial begin : stimulus
    stim_row_t  directed_rows [$];
    match_cfg_t cfg_plan [8];
    int         target, p;

    directed_rows.push_back(row(CMD_QUERY, ONES, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1,
                                match_of(16'h0000, 10'd0, 13'd0, ST_EMPTY)));
    directed_rows.push_back(row(CMD_UNUSED, ONES, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed_rows.push_back(row(CMD_LOAD, ZEROS, 16'h0000, 16'h0000, 16'h0001));
    directed_rows.push_back(row(CMD_QUERY, ZEROS, 16'h0000, 16'h0000, 16'hFFFF, 1'b1,
                                match_of(16'hFFFF, 10'd0, 13'd0, ST_ACCEPTED)));
    directed_rows.push_back(row(CMD_QUERY, ONES, 16'h0000, 16'h0000, 16'h0001, 1'b1,
                                match_of(16'h0001, 10'd0, 13'd256, ST_ACCEPTED)));
    directed_rows.push_back(row(CMD_LOAD, ZEROS, 16'hFFFF, 16'hFFFF, 16'h0002));
    directed_rows.push_back(row(CMD_QUERY, ZEROS, 16'h0000, 16'h0000, 16'h0002, 1'b1,
                                match_of(16'h0002, 10'd0, 13'd0, ST_REJECTED)));
    directed_rows.push_back(row(CMD_CLEAR, ONES, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed_rows.push_back(row(CMD_QUERY, ZEROS, 16'h0000, 16'h0000, 16'h0003, 1'b1,
                                match_of(16'h0003, 10'd0, 13'd0, ST_EMPTY)));
    directed_rows.push_back(row(CMD_LOAD, ALT, 16'h0000, 16'h0000, 16'h0004));
    directed_rows.push_back(row(CMD_LOAD, ~ALT, 16'd100, 16'd100, 16'h0005));
    directed_rows.push_back(row(CMD_LOAD, ONES, 16'd1600, 16'h0000, 16'h0006));
    directed_rows.push_back(row(CMD_QUERY, ALT ^ 256'h1, 16'h0000, 16'h0000, 16'h0007));
    directed_rows.push_back(row(CMD_QUERY, ONES, 16'd1600, 16'h0000, 16'h0008));
    directed_rows.push_back(row(CMD_QUERY, {{128{1'b0}}, {128{1'b1}}}, 16'h0000,
                                16'h0000, 16'h0009, 1'b1,
                                match_of(16'h0009, 10'd0, 13'd128, ST_REJECTED)));

    cfg_plan[0] = '{1'b1, 9'd205, 1'b1, 16'd1600, 5'd2};
    cfg_plan[1] = '{1'b0, 9'd205, 1'b1, 16'd0, 5'd16};
    cfg_plan[2] = '{1'b1, 9'd0, 1'b0, 16'd1600, 5'd2};
    cfg_plan[3] = '{1'b1, 9'd256, 1'b1, 16'd65535, 5'd1};
    cfg_plan[4] = '{1'b1, 9'd511, 1'b1, 16'd800, 5'd0};
    cfg_plan[5] = '{1'b1, 9'd230, 1'b1, 16'd400, 5'd31};
    cfg_plan[6] = '{1'b0, 9'd0, 1'b0, 16'd0, 5'd1};
    cfg_plan[7] = '{1'b1, 9'd180, 1'b1, 16'd2000, 5'd3};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    snd_pct = 14;
    rcv_pct = 14;
    foreach (directed_rows[k])
      send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].result);

    // load a larger set, then match against first, middle and last entries
    snd_pct = 0;
    rcv_pct = 0;
    send_request(make_req(CMD_CLEAR, ZEROS, 16'h0000, 16'h0000, 16'h0000));
    ep_count = 0;
    repeat (BIG_SET) load_entry();
    send_request(make_req(CMD_QUERY, ep_desc[BIG_SET-1], ep_x[BIG_SET-1],
                          ep_y[BIG_SET-1], 16'hA5A5));
    send_request(make_req(CMD_QUERY, flip_bits(ep_desc[BIG_SET/2], 3),
                          ep_x[BIG_SET/2], ep_y[BIG_SET/2], 16'h5A5A));
    send_request(make_req(CMD_QUERY, ep_desc[0], ep_x[0], ep_y[0], 16'h0F0F));
    send_request(make_req(CMD_QUERY, rand_desc(), rand_pos(), rand_pos(), 16'hF0F0));
    wait_drained();

    for (p = 0; p < 8; p++) begin
      apply_cfg(cfg_plan[p]);
      case (p % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 65; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 65; end
        default: begin snd_pct = 14; rcv_pct = 14; end
      endcase
      target = items_sent + PHASE_ITEMS;
      if (p == 2) begin
        hold_pending = 1'b1;
        run_episode(4);
      end else if (p == 5) begin
        run_episode(2);
        wait_drained();
      end
      while (items_sent < target) run_episode(1);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[hamming_descriptor_matcher] OK");
    end else begin
      $display("[hamming_descriptor_matcher] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("[hamming_descriptor_matcher] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hdm_pkg.sv
hw/rtl/hdm_ctrl.sv
hw/rtl/hdm_datapath.sv
hw/rtl/hamming_descriptor_matcher.sv
dv/testbench.sv
